FILE: rtl/median_filter_3x3_macros.svh
// Assertion macros for the median filter, empty when synthesized.
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define MF3_ASSERT(lbl, prop, msg)
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

  localparam int unsigned PixelBits       = 8;
  localparam int unsigned CfgW            = 11;
  localparam int unsigned RowW            = 10;
  localparam int unsigned OutColW         = 10;
  localparam int unsigned DefaultMaxWidth = 1024;
  localparam int unsigned MaxHeight       = 1024;
  localparam int unsigned MinSize         = 3;
  localparam int unsigned WidthReset      = 512;
  localparam int unsigned HeightReset     = 512;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QAddrW          = $clog2(QueueDepth);
  localparam int unsigned QCntW           = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW         = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  typedef logic [PixelBits-1:0] pix_t;

  // Window laid out as [row*3 + col], row 0 oldest, col 2 newest
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
  } cfg_t;

  typedef struct packed {
    win_t               win;
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic               last;
  } win_item_t;

  typedef struct packed {
    pix_t               median;
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic               last;
  } res_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_stat_t;

endpackage

FILE: rtl/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port; a read of the same address in the same cycle sees old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mf3_front.sv
// Front end: position counters, line stores and the 3x3 window.
module mf3_front import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefaultMaxWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pix_t      pixel_i,
  input  logic      frame_start_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output win_item_t push_item_o,
  output logic      busy_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned SzW  = (ColW + 1 > CfgW) ? ColW + 2 : CfgW + 1;
  localparam int unsigned HW   = CfgW + 1;

  logic [SzW-1:0] w_raw, w_eff, c_ext;
  logic [HW-1:0]  h_raw, h_eff, r_ext;

  logic [RowW-1:0] row_q, row_d, cur_r;
  logic [ColW-1:0] col_q, col_d, cur_c;

  logic accept, emit, last;

  logic               s1_v_q, s1_v_d;
  pix_t               s1_px_q;
  logic [ColW-1:0]    s1_idx_q;
  logic               s1_emit_q;
  logic [RowW-1:0]    s1_row_q;
  logic [OutColW-1:0] s1_col_q;
  logic               s1_last_q;
  logic               s1_byp_q;
  pix_t               s1_byp_a_q, s1_byp_b_q;
  logic               s1_fire, bypass;

  pix_t rd_a, rd_b, above, above2;
  win_t win_q, win_d;

  // Clamp the configured frame size
  always_comb begin
    w_raw = SzW'(cfg_i.width);
    if (w_raw < SzW'(MinSize)) begin
      w_eff = SzW'(MinSize);
    end else if (w_raw > SzW'(MAX_WIDTH)) begin
      w_eff = SzW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = HW'(cfg_i.height);
    if (h_raw < HW'(MinSize)) begin
      h_eff = HW'(MinSize);
    end else if (h_raw > HW'(MaxHeight)) begin
      h_eff = HW'(MaxHeight);
    end else begin
      h_eff = h_raw;
    end
  end

  // Place the incoming pixel and classify it
  assign s1_fire    = s1_v_q && (!s1_emit_q || push_ready_i);
  assign in_ready_o = !s1_v_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  assign cur_r = frame_start_i ? '0 : row_q;
  assign cur_c = frame_start_i ? '0 : col_q;
  assign c_ext = SzW'(cur_c);
  assign r_ext = HW'(cur_r);

  assign emit = (r_ext >= HW'(2)) && (c_ext >= SzW'(2)) && (r_ext < h_eff) && (c_ext < w_eff);
  assign last = (r_ext == h_eff - HW'(1)) && (c_ext == w_eff - SzW'(1));

  // Advance the position, wrapping at row and frame end
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (c_ext + SzW'(1) >= w_eff) begin
        col_d = '0;
        row_d = (r_ext + HW'(1) >= h_eff) ? '0 : cur_r + RowW'(1);
      end else begin
        col_d = cur_c + ColW'(1);
        row_d = cur_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Forward the write of the leaving request when it hits the same column
  assign bypass = s1_fire && (s1_idx_q == cur_c);

  assign s1_v_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= pixel_i;
      s1_idx_q   <= cur_c;
      s1_emit_q  <= emit;
      s1_row_q   <= cur_r - RowW'(1);
      s1_col_q   <= OutColW'(c_ext - SzW'(1));
      s1_last_q  <= last;
      s1_byp_q   <= bypass;
      s1_byp_a_q <= s1_px_q;
      s1_byp_b_q <= above;
    end
  end

  // Line stores: previous row and the row before it
  mf3_ram #(.Width(PixelBits), .Depth(MAX_WIDTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (cur_c),
    .rdata_o (rd_a)
  );

  mf3_ram #(.Width(PixelBits), .Depth(MAX_WIDTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_idx_q),
    .wdata_i (above),
    .re_i    (accept),
    .raddr_i (cur_c),
    .rdata_o (rd_b)
  );

  assign above  = s1_byp_q ? s1_byp_a_q : rd_a;
  assign above2 = s1_byp_q ? s1_byp_b_q : rd_b;

  // Shift the window one column and bring in the new column
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3 + 0] = win_q[k*3 + 1];
      win_d[k*3 + 1] = win_q[k*3 + 2];
    end
    win_d[2] = above2;
    win_d[5] = above;
    win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  // Hand interior positions to the queue
  assign push_valid_o     = s1_v_q && s1_emit_q;
  assign push_item_o.win  = win_d;
  assign push_item_o.row  = s1_row_q;
  assign push_item_o.col  = s1_col_q;
  assign push_item_o.last = s1_last_q;
  assign busy_o           = s1_v_q;

endmodule

FILE: rtl/mf3_queue.sv
// Short request queue between the front end and the median unit.
module mf3_queue import mf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  win_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output win_item_t pop_item_o,
  output q_stat_t   stat_o
);

  win_item_t         mem_q [QueueDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAddrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAddrW'(1);
      end
      count_q <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign stat_o.empty = !pop_valid_o;
  assign stat_o.full  = !push_ready_o;
  assign stat_o.count = count_q;

endmodule

FILE: rtl/mf3_back.sv
// Back end: pipelined nine-input median network with output register.
module mf3_back import mf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  win_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      out_res_o
);

  // Order two pixels: {smaller, larger}
  function automatic logic [2*PixelBits-1:0] srt(pix_t a, pix_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  win_t p1, p2, p3;
  win_t b1_win_q, b2_win_q;
  win_item_t b1_meta_q, b2_meta_q;
  logic b1_v_q, b2_v_q, o_v_q;
  logic en1, en2, en3;
  res_t o_res_q;

  assign en3 = !o_v_q || out_ready_i;
  assign en2 = !b2_v_q || en3;
  assign en1 = !b1_v_q || en2;
  assign in_ready_o = en1;

  // Sort each row of three
  always_comb begin
    p1 = in_item_i.win;
    {p1[1], p1[2]} = srt(p1[1], p1[2]);
    {p1[4], p1[5]} = srt(p1[4], p1[5]);
    {p1[7], p1[8]} = srt(p1[7], p1[8]);
    {p1[0], p1[1]} = srt(p1[0], p1[1]);
    {p1[3], p1[4]} = srt(p1[3], p1[4]);
    {p1[6], p1[7]} = srt(p1[6], p1[7]);
    {p1[1], p1[2]} = srt(p1[1], p1[2]);
    {p1[4], p1[5]} = srt(p1[4], p1[5]);
    {p1[7], p1[8]} = srt(p1[7], p1[8]);
  end

  // Prune across rows
  always_comb begin
    p2 = b1_win_q;
    {p2[0], p2[3]} = srt(p2[0], p2[3]);
    {p2[5], p2[8]} = srt(p2[5], p2[8]);
    {p2[4], p2[7]} = srt(p2[4], p2[7]);
    {p2[3], p2[6]} = srt(p2[3], p2[6]);
    {p2[1], p2[4]} = srt(p2[1], p2[4]);
    {p2[2], p2[5]} = srt(p2[2], p2[5]);
    {p2[4], p2[7]} = srt(p2[4], p2[7]);
  end

  // Settle the middle element
  always_comb begin
    p3 = b2_win_q;
    {p3[4], p3[2]} = srt(p3[4], p3[2]);
    {p3[6], p3[4]} = srt(p3[6], p3[4]);
    {p3[4], p3[2]} = srt(p3[4], p3[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (en1) begin
        b1_v_q <= in_valid_i;
      end
      if (en2) begin
        b2_v_q <= b1_v_q;
      end
      if (en3) begin
        o_v_q <= b2_v_q;
      end
    end
  end

  // Advance payload along the stages
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      b1_win_q  <= p1;
      b1_meta_q <= in_item_i;
    end
    if (en2 && b1_v_q) begin
      b2_win_q  <= p2;
      b2_meta_q <= b1_meta_q;
    end
    if (en3 && b2_v_q) begin
      o_res_q.median <= p3[4];
      o_res_q.row    <= b2_meta_q.row;
      o_res_q.col    <= b2_meta_q.col;
      o_res_q.last   <= b2_meta_q.last;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_res_o   = o_res_q;

endmodule

FILE: rtl/median_filter_3x3.sv
// Top level of the 3x3 median filter: configuration registers and block wiring.
// Streams 8-bit pixels in raster order and returns, for each interior position, the median
// of its 3x3 neighbourhood with the centre's row and column; border positions give no
// result. One pixel is taken every clock while the output side keeps up: the line-store
// stage reads both MAX_WIDTH x 8 line RAMs once per pixel and writes them back as the pixel
// leaves the stage, and the sorting network is a three-stage pipeline. A four-entry queue
// and an output register let the input run on while a result waits. Line RAMs are not
// cleared; the first two rows of each frame fill them before any result reads them.
// The user must write configuration only while the block is idle; the block itself
// does not enforce it.
`include "median_filter_3x3_macros.svh"

module median_filter_3x3 import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefaultMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixelBits-1:0] pixel_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixelBits-1:0] median_value_o,
  output logic [RowW-1:0]     out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic                frame_last_o
);

  cfg_t      cfg_q;
  logic      q_push_valid, q_push_ready, q_pop_valid, back_ready, q_pop;
  win_item_t q_push_item, q_pop_item;
  q_stat_t   q_stat;
  res_t      res;
  logic      front_busy;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= CfgW'(WidthReset);
      cfg_q.height <= CfgW'(HeightReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  cfg_q.width  <= cfg_wdata_i;
        CfgImageHeight: cfg_q.height <= cfg_wdata_i;
      endcase
    end
  end

  mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .push_valid_o  (q_push_valid),
    .push_ready_i  (q_push_ready),
    .push_item_o   (q_push_item),
    .busy_o        (front_busy)
  );

  mf3_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (q_pop_item),
    .stat_o       (q_stat)
  );

  mf3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_pop_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (q_pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign q_pop          = q_pop_valid && back_ready;
  assign median_value_o = res.median;
  assign out_row_o      = res.row;
  assign out_col_o      = res.col;
  assign frame_last_o   = res.last;

  // Assertions
  `MF3_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "queue popped while empty")
  `MF3_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full, "full queue lost an entry")
  `MF3_ASSERT(a_count_bound, q_stat.count <= QCntW'(QueueDepth), "queue count beyond depth")
  `MF3_ASSERT_NEXT(a_accept_loads, in_valid_i && in_ready_o, front_busy, "request did not load")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the 3x3 median filter: pixel driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
  import mf3_pkg::*;

  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = 16;
  localparam int RandomPixels = 650;
  localparam int TailPixels   = 250;

  typedef enum int {PixUniform, PixExtreme, PixNarrow, PixFew} pix_mode_e;

  typedef struct {
    pix_t px;
    logic fs;
    logic drain;
  } pix_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = CfgImageWidth;
  logic [CfgW-1:0]      cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [PixelBits-1:0] pixel_i       = '0;
  logic                 frame_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [PixelBits-1:0] median_value_o;
  logic [RowW-1:0]      out_row_o;
  logic [OutColW-1:0]   out_col_o;
  logic                 frame_last_o;

  median_filter_3x3 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .median_value_o(median_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_last_o  (frame_last_o)
  );

  // Pending pixel requests and predicted medians
  pix_req_t pixel_q [$];
  res_t     median_q [$];

  // Predictor state
  logic [CfgW-1:0]    img_width_q  = CfgW'(WidthReset);
  logic [CfgW-1:0]    img_height_q = CfgW'(HeightReset);
  pix_t               line_a [DefaultMaxWidth];
  pix_t               line_b [DefaultMaxWidth];
  pix_t               win_q [9];
  logic [RowW-1:0]    row_pos = '0;
  logic [OutColW-1:0] col_pos = '0;

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  send_gap       = 0;
  int  ready_stall    = 0;
  bit  steady_phase   = 1'b0;

  initial begin
    for (int k = 0; k < 9; k++) win_q[k] = '0;
  end

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Effective frame dimension after saturation
  function automatic int clamp_size(input logic [CfgW-1:0] v, input int hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  // Advance the window by one pixel and predict the median it produces, if any
  task automatic filter_pixel(input pix_t px, input logic fs);
    int   w, h, r, c, idx, lt, le;
    pix_t above, above2;
    res_t exp_res;
    w = clamp_size(img_width_q, DefaultMaxWidth);
    h = clamp_size(img_height_q, MaxHeight);
    if (fs) begin
      row_pos = '0;
      col_pos = '0;
    end
    r   = row_pos;
    c   = col_pos;
    idx = (c < DefaultMaxWidth) ? c : 0;

    // Shift line stores
    above       = line_a[idx];
    above2      = line_b[idx];
    line_b[idx] = above;
    line_a[idx] = px;

    // Shift window left, new column on the right
    for (int k = 0; k < 3; k++) begin
      win_q[k*3]   = win_q[k*3+1];
      win_q[k*3+1] = win_q[k*3+2];
    end
    win_q[2] = above2;
    win_q[5] = above;
    win_q[8] = px;

    // Interior position: the median is the value with at most 4 below and at least 5 at or below
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      exp_res.median = win_q[0];
      for (int i = 0; i < 9; i++) begin
        lt = 0;
        le = 0;
        for (int j = 0; j < 9; j++) begin
          if (win_q[j] < win_q[i]) lt++;
          if (win_q[j] <= win_q[i]) le++;
        end
        if (lt <= 4 && le >= 5) exp_res.median = win_q[i];
      end
      exp_res.row  = RowW'(r - 1);
      exp_res.col  = OutColW'(c - 1);
      exp_res.last = (r == h - 1) && (c == w - 1);
      median_q.push_back(exp_res);
    end

    // Advance position, wrap at row and frame end
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : RowW'(r + 1);
    end else begin
      col_pos = OutColW'(c + 1);
    end
  endtask

  // Driver: present pixel requests, predict on acceptance
  always @(posedge clk_i) begin
    logic    valid_n;
    pix_req_t req;
    if (rst_ni) begin
      valid_n = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        filter_pixel(pixel_i, frame_start_i);
        valid_n  = 1'b0;
        send_gap = idle_gap();
      end
      if (!valid_n) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() != 0 &&
                     (!pixel_q[0].drain || median_q.size() == 0)) begin
          req           = pixel_q.pop_front();
          pixel_i       <= req.px;
          frame_start_i <= req.fs;
          valid_n       = 1'b1;
        end
      end
      in_valid_i <= valid_n;
    end
  end

  // Monitor: check each accepted result against the oldest prediction, stall at random
  always @(posedge clk_i) begin
    res_t exp_res;
    logic ready_n;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (median_q.size() == 0) begin
          $error("unexpected result: row %0d col %0d median %0d",
                 out_row_o, out_col_o, median_value_o);
          mismatch_count++;
        end else begin
          exp_res = median_q.pop_front();
          if (median_value_o !== exp_res.median) begin
            $error("median_value: expected %0d, got %0d", exp_res.median, median_value_o);
            mismatch_count++;
          end
          if (out_row_o !== exp_res.row) begin
            $error("out_row: expected %0d, got %0d", exp_res.row, out_row_o);
            mismatch_count++;
          end
          if (out_col_o !== exp_res.col) begin
            $error("out_col: expected %0d, got %0d", exp_res.col, out_col_o);
            mismatch_count++;
          end
          if (frame_last_o !== exp_res.last) begin
            $error("frame_last: expected %0d, got %0d", exp_res.last, frame_last_o);
            mismatch_count++;
          end
        end
      end
      if (ready_stall > 0) begin
        ready_stall--;
        ready_n = 1'b0;
      end else begin
        ready_n     = 1'b1;
        ready_stall = idle_gap();
      end
      out_ready_i <= ready_n;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Wait until every request is sent and every result has come, then let the pipe drain
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || median_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgImageWidth) img_width_q = val;
    else img_height_q = val;
  endtask

  task automatic set_size(input logic [CfgW-1:0] w_raw, input logic [CfgW-1:0] h_raw);
    wait_idle();
    write_reg(CfgImageWidth, w_raw);
    write_reg(CfgImageHeight, h_raw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Configure a frame size and queue a run of pixels with random content
  task automatic feed_phase(input logic [CfgW-1:0] w_raw, input logic [CfgW-1:0] h_raw,
                            input int count, input bit want_start, input bit noisy);
    int        old_w, v;
    bit        start_frame, fs, drain;
    pix_mode_e mode;
    pix_t      base, px;
    old_w = clamp_size(img_width_q, DefaultMaxWidth);
    set_size(w_raw, h_raw);
    // A wider row needs a fresh frame so the line stores fill before use
    start_frame  = want_start || (clamp_size(w_raw, DefaultMaxWidth) > old_w);
    steady_phase = ($urandom_range(0, 3) == 0);
    mode         = pix_mode_e'($urandom_range(0, 3));
    base         = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      case (mode)
        PixUniform: px = $urandom_range(0, 255);
        PixExtreme: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        PixNarrow: begin
          v  = int'($urandom_range(0, 6)) - 3 + int'(base);
          px = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : pix_t'(v);
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       px = base;
            1:       px = base ^ 8'h5a;
            default: px = ~base;
          endcase
        end
      endcase
      fs    = (i == 0 && start_frame) || (noisy && i > 0 && $urandom_range(0, 199) == 0);
      drain = (i == count / 2) ? !noisy : (noisy && $urandom_range(0, 99) == 0);
      pixel_q.push_back('{px, fs, drain});
    end
  endtask

  // Stimulus
  initial begin
    int rand_items, ew, eh, n, r, left;
    logic [CfgW-1:0] w_raw, h_raw;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sizes below the minimum act as 3x3; alternating extremes in one frame
    set_size(11'd1, 11'd2);
    pixel_q.push_back('{8'd255, 1'b1, 1'b0});
    pixel_q.push_back('{8'd0,   1'b0, 1'b0});
    pixel_q.push_back('{8'd255, 1'b0, 1'b0});
    pixel_q.push_back('{8'd0,   1'b0, 1'b0});
    pixel_q.push_back('{8'd255, 1'b0, 1'b0});
    pixel_q.push_back('{8'd0,   1'b0, 1'b0});
    pixel_q.push_back('{8'd255, 1'b0, 1'b0});
    pixel_q.push_back('{8'd0,   1'b0, 1'b0});
    pixel_q.push_back('{8'd255, 1'b0, 1'b0});
    // Frame wraps on its own, then restarts mid-row on frame_start
    pixel_q.push_back('{8'd7,   1'b0, 1'b0});
    pixel_q.push_back('{8'd200, 1'b1, 1'b0});
    pixel_q.push_back('{8'd3,   1'b0, 1'b0});
    pixel_q.push_back('{8'd3,   1'b0, 1'b0});
    pixel_q.push_back('{8'd3,   1'b0, 1'b0});
    pixel_q.push_back('{8'd90,  1'b0, 1'b0});
    pixel_q.push_back('{8'd91,  1'b0, 1'b0});
    pixel_q.push_back('{8'd92,  1'b0, 1'b0});
    pixel_q.push_back('{8'd1,   1'b0, 1'b0});
    pixel_q.push_back('{8'd254, 1'b0, 1'b0});

    // Stop mid-frame at row 6 col 7, then shrink both sizes below the position
    feed_phase(11'd8, 11'd8, 55, 1'b1, 1'b0);
    feed_phase(11'd5, 11'd4, 40, 1'b0, 1'b1);
    rand_items = 114;

    // Random frame sizes, mostly small
    while (rand_items < RandomPixels - TailPixels) begin
      r = $urandom_range(0, 99);
      if (r < 10) w_raw = $urandom_range(0, 2);
      else if (r < 75) w_raw = $urandom_range(3, 12);
      else if (r < 95) w_raw = $urandom_range(13, 48);
      else w_raw = $urandom_range(49, 200);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      ew = clamp_size(w_raw, DefaultMaxWidth);
      eh = clamp_size(h_raw, MaxHeight);
      n  = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
      if (n > 400) n = 3 * ew + $urandom_range(0, ew);
      left = RandomPixels - TailPixels - rand_items;
      if (n > left) n = left;
      feed_phase(w_raw, h_raw, n, $urandom_range(0, 1), 1'b1);
      rand_items += n;
    end

    // Rows wider than the maximum, then a frame taller than the maximum
    feed_phase(11'd2047, 11'd0, 100, 1'b1, 1'b0);
    feed_phase(11'd3, 11'd2047, TailPixels - 100, 1'b1, 1'b0);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
